/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: command and
// status codes, cell operations and sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned PosW         = 5;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned DepthDefault = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_DELETE     = 3'd2,
    CMD_SWAP       = 3'd3,
    CMD_READ_FRONT = 3'd4,
    CMD_READ_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // What every cell does this cycle, relative to the broadcast position.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,  // above pos: take left word; at pos: take data
    CELL_DELETE = 2'd2,  // at or above pos: take right word
    CELL_LOAD   = 2'd3   // at pos: take data
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] data;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SWAP_A = 2'd1,
    S_SWAP_B = 2'd2,
    S_READ   = 2'd3
  } seq_state_e;

endpackage

/* rtl/core/ple_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Holds one word and takes its neighbor's word when the
// list opens or closes a gap at or below this slot.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                     clk_i,
  input  ple_pkg::cell_cmd_t       cmd_i,
  input  logic [IdxW-1:0]          pos_i,
  input  logic [ple_pkg::DataW-1:0] left_i,
  input  logic [ple_pkg::DataW-1:0] right_i,
  output logic [ple_pkg::DataW-1:0] value_o
);
  import ple_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic [DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          value_d = left_i;
        end else if (MyIdx == pos_i) begin
          value_d = cmd_i.data;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_i) begin
          value_d = right_i;
        end
      end
      CELL_LOAD: begin
        if (MyIdx == pos_i) begin
          value_d = cmd_i.data;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* rtl/core/ple_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Command sequencer: checks positions, keeps the element count, drives the
// cell row and the read tap, and registers every result word.
// ----------------------------------------------------------------------------
module ple_ctrl #(
  parameter int unsigned Depth = ple_pkg::DepthDefault,
  parameter int unsigned IdxW  = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ple_pkg::CmdW-1:0]     command_i,
  input  logic [ple_pkg::DataW-1:0]    value_i,
  input  logic [ple_pkg::PosW-1:0]     position_a_i,
  input  logic [ple_pkg::PosW-1:0]     position_b_i,
  output logic                         busy_o,
  output logic                         valid_o,
  output logic [ple_pkg::StatusW-1:0]  status_o,
  output logic [ple_pkg::DataW-1:0]    element_o,
  output logic [ple_pkg::PosW-1:0]     element_position_o,
  output logic                         last_o,
  output logic [IdxW-1:0]              rd_sel_o,
  input  logic [ple_pkg::DataW-1:0]    rd_data_i,
  output ple_pkg::cell_cmd_t           cell_cmd_o,
  output logic [IdxW-1:0]              cell_pos_o
);
  import ple_pkg::*;

  // Wide enough for count + 1 and for any position field.
  localparam int unsigned WideW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  seq_state_e state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    ia_q, ia_d, ib_q, ib_d, idx_q, idx_d;
  logic               back_q, back_d;
  logic [DataW-1:0]   tmp_q, tmp_d;

  logic               valid_q, valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [DataW-1:0]   elem_q, elem_d;
  logic [PosW-1:0]    epos_q, epos_d;
  logic               last_q, last_d;

  logic [WideW-1:0] cnt_w, pa_w, pb_w, pa_m1, pb_m1, cnt_m1, idx_p1;
  logic [IdxW-1:0]  idx_a, idx_b, idx_cnt, idx_end;
  logic             full, ins_ok, del_ok, swap_ok, read_last;

  always_comb begin
    cnt_w   = WideW'(count_q);
    pa_w    = WideW'(position_a_i);
    pb_w    = WideW'(position_b_i);
    pa_m1   = pa_w - WideW'(1);
    pb_m1   = pb_w - WideW'(1);
    cnt_m1  = cnt_w - WideW'(1);
    idx_p1  = WideW'(idx_q) + WideW'(1);
    idx_a   = pa_m1[IdxW-1:0];
    idx_b   = pb_m1[IdxW-1:0];
    idx_cnt = cnt_w[IdxW-1:0];
    idx_end = cnt_m1[IdxW-1:0];
    full    = (count_q == FullCnt);
    ins_ok  = (pa_w != '0) && (pa_w <= cnt_w + WideW'(1));
    del_ok  = (pa_w != '0) && (pa_w <= cnt_w);
    swap_ok = del_ok && (pb_w != '0) && (pb_w <= cnt_w);
    read_last = back_q ? (idx_q == '0) : (idx_q == idx_end);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    idx_d      = idx_q;
    back_d     = back_q;
    tmp_d      = tmp_q;
    valid_d    = 1'b0;
    status_d   = ST_OK;
    elem_d     = '0;
    epos_d     = '0;
    last_d     = 1'b1;
    rd_sel_o   = idx_a;
    cell_cmd_o = '{op: CELL_HOLD, data: value_i};
    cell_pos_o = idx_a;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_e'(command_i))
            CMD_APPEND: begin
              valid_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                cell_pos_o    = idx_cnt;
                count_d       = count_q + CntW'(1);
              end
            end
            CMD_INSERT: begin
              valid_d = 1'b1;
              if (!ins_ok) begin
                status_d = ST_REJECT;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                count_d       = count_q + CntW'(1);
              end
            end
            CMD_DELETE: begin
              valid_d = 1'b1;
              if (!del_ok) begin
                status_d = ST_REJECT;
              end else begin
                cell_cmd_o.op = CELL_DELETE;
                count_d       = count_q - CntW'(1);
              end
            end
            CMD_SWAP: begin
              if (position_a_i == position_b_i) begin
                valid_d = 1'b1;
              end else if (!swap_ok) begin
                valid_d  = 1'b1;
                status_d = ST_REJECT;
              end else begin
                // tap reads slot a now; hold it until slot b is known
                tmp_d   = rd_data_i;
                ia_d    = idx_a;
                ib_d    = idx_b;
                state_d = S_SWAP_A;
              end
            end
            CMD_READ_FRONT, CMD_READ_BACK: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                back_d  = (cmd_e'(command_i) == CMD_READ_BACK);
                idx_d   = (cmd_e'(command_i) == CMD_READ_BACK) ? idx_end : '0;
                state_d = S_READ;
              end
            end
            default: begin
              valid_d  = 1'b1;
              status_d = ST_REJECT;
            end
          endcase
        end
      end
      S_SWAP_A: begin
        rd_sel_o        = ib_q;
        cell_cmd_o.op   = CELL_LOAD;
        cell_cmd_o.data = rd_data_i;
        cell_pos_o      = ia_q;
        state_d         = S_SWAP_B;
      end
      S_SWAP_B: begin
        cell_cmd_o.op   = CELL_LOAD;
        cell_cmd_o.data = tmp_q;
        cell_pos_o      = ib_q;
        valid_d         = 1'b1;
        state_d         = S_IDLE;
      end
      S_READ: begin
        rd_sel_o = idx_q;
        valid_d  = 1'b1;
        elem_d   = rd_data_i;
        epos_d   = idx_p1[PosW-1:0];
        last_d   = read_last;
        if (read_last) begin
          state_d = S_IDLE;
        end else if (back_q) begin
          idx_d = idx_q - IdxW'(1);
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q     <= ia_d;
    ib_q     <= ib_d;
    idx_q    <= idx_d;
    back_q   <= back_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    elem_q   <= elem_d;
    epos_q   <= epos_d;
    last_q   <= last_d;
  end

  assign busy_o             = (state_q != S_IDLE);
  assign valid_o            = valid_q;
  assign status_o           = status_q;
  assign element_o          = elem_q;
  assign element_position_o = epos_q;
  assign last_o             = last_q;

endmodule

/* rtl/core/positional_list_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of signed 32-bit words held in a row of cells.
// ----------------------------------------------------------------------------
// Issue a command by raising start_i while busy_o is low; it is taken at that
// clock edge. Every result word shows on the result ports for one cycle with
// valid_o high, and there is no way to stall it, so sample it when valid_o is
// high. Append, insert and delete finish in the accept cycle: the list shifts
// all cells at once, the status word shows in the next cycle and busy_o stays
// low, so these edits can be issued back to back. A swap goes through the
// single read tap twice, keeping busy_o high through states S_SWAP_A and
// S_SWAP_B, and its status word is registered out after S_SWAP_B. A read-out
// walks the tap over the list one cell a cycle in state S_READ with busy_o
// high, each word registered out, the final one flagged by last_o; an empty
// list gives one empty status word in the next cycle. The read tap is what
// sets the read-out and swap lengths. The next command may be taken in the
// cycle that shows the final result word. Every edit result, and every
// rejected or empty status, comes with last_o high and zero element fields.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned DEPTH = ple_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [ple_pkg::CmdW-1:0]    command_i,
  input  logic [ple_pkg::DataW-1:0]   value_i,
  input  logic [ple_pkg::PosW-1:0]    position_a_i,
  input  logic [ple_pkg::PosW-1:0]    position_b_i,
  output logic                        valid_o,
  output logic [ple_pkg::StatusW-1:0] status_o,
  output logic [ple_pkg::DataW-1:0]   element_o,
  output logic [ple_pkg::PosW-1:0]    element_position_o,
  output logic                        last_o
);
  import ple_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW:0] DepthIdx = (IdxW + 1)'(DEPTH);

  // Broadcast command to the whole row, plus the read tap.
  cell_cmd_t        cell_cmd;
  logic [IdxW-1:0]  cell_pos;
  logic [IdxW-1:0]  rd_sel;
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] cell_val [DEPTH];

  ple_ctrl #(
    .Depth (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .command_i          (command_i),
    .value_i            (value_i),
    .position_a_i       (position_a_i),
    .position_b_i       (position_b_i),
    .busy_o             (busy_o),
    .valid_o            (valid_o),
    .status_o           (status_o),
    .element_o          (element_o),
    .element_position_o (element_position_o),
    .last_o             (last_o),
    .rd_sel_o           (rd_sel),
    .rd_data_i          (rd_data),
    .cell_cmd_o         (cell_cmd),
    .cell_pos_o         (cell_pos)
  );

  // Row of cells: slot k holds list position k+1. Each cell sees its two
  // neighbors; the ends feed back their own word, so the last cell keeps its word on a delete.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = cell_val[k];
    end else begin : g_mid_l
      assign left_w = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_final
      assign right_w = cell_val[k];
    end else begin : g_mid_r
      assign right_w = cell_val[k+1];
    end

    ple_cell #(
      .IdxW (IdxW),
      .Idx  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .pos_i   (cell_pos),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[k])
    );
  end

  // Single read tap; a select past the row (only when DEPTH is not a power of
  // two or is 1, and then the word read goes unused) reads zero.
  always_comb begin
    if ({1'b0, rd_sel} < DepthIdx) begin
      rd_data = cell_val[rd_sel];
    end else begin
      rd_data = '0;
    end
  end

  // A read-out streams without gaps until its flagged word.
  a_stream_gapless : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o
  ) else $error("read-out stream broke before its final word");

  // Append, insert and delete answer in the very next cycle with one flagged word.
  a_edit_answer : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (command_i == CMD_APPEND || command_i == CMD_INSERT
                           || command_i == CMD_DELETE)
    |=> valid_o && last_o && (element_o == '0) && (element_position_o == '0)
  ) else $error("edit did not answer with one status word");

  // Any non-ok status is a single flagged word with zero element fields.
  a_status_word : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_OK)
    |-> last_o && (element_o == '0) && (element_position_o == '0)
  ) else $error("error status word carries element data");

  // While the sequencer is free, no read-out word other than the final one
  // may still be showing.
  a_idle_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o && !busy_o |-> last_o
  ) else $error("sequencer went idle in the middle of a read-out");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_engine_unit. Directed tests cover
// the empty and full list, position edges, self swaps and spare command
// codes. Random tests then run mostly well-formed edits and read-outs under
// several levels of sender idling. Every result word is checked against an
// in-bench list model.
// ----------------------------------------------------------------------------
module testbench;
  import ple_pkg::*;

  localparam int unsigned ListDepth  = ple_pkg::DepthDefault;
  localparam int unsigned CycleLimit = 100000;
  // Command codes the block does not define; both must be rejected.
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  // One result word as the block should present it.
  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] element;
    logic [PosW-1:0]  position;
    logic             last;
  } list_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [CmdW-1:0]     command_i = '0;
  logic [DataW-1:0]    value_i = '0;
  logic [PosW-1:0]     position_a_i = '0;
  logic [PosW-1:0]     position_b_i = '0;
  logic                busy_o;
  logic                valid_o;
  logic [StatusW-1:0]  status_o;
  logic [DataW-1:0]    element_o;
  logic [PosW-1:0]     element_position_o;
  logic                last_o;

  // Bench copy of the list contents, front at index 0.
  logic [DataW-1:0]    list_q[$];
  // Words still owed by the block, oldest first.
  list_word_t          pending_words[$];

  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned command_count = 0;
  int unsigned word_count = 0;
  int unsigned full_count = 0;
  int unsigned read_count = 0;

  always #5 clk_i = ~clk_i;

  positional_list_engine_unit #(
    .DEPTH(ListDepth)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .value_i            (value_i),
    .position_a_i       (position_a_i),
    .position_b_i       (position_b_i),
    .valid_o            (valid_o),
    .status_o           (status_o),
    .element_o          (element_o),
    .element_position_o (element_position_o),
    .last_o             (last_o)
  );

  // Apply one command to the list copy and queue the words it must produce.
  function automatic void predict_list_op(input logic [CmdW-1:0] cmd,
                                          input logic [DataW-1:0] val,
                                          input logic [PosW-1:0] pos_a,
                                          input logic [PosW-1:0] pos_b);
    int unsigned size;
    int unsigned idx;
    status_e     st;
    logic [DataW-1:0] tmp;
    size = list_q.size();
    st = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (size >= ListDepth) begin
          st = ST_FULL;
        end else begin
          list_q.push_back(val);
        end
      end
      CMD_INSERT: begin
        // Position check wins over the full check.
        if (pos_a < 1 || pos_a > size + 1) begin
          st = ST_REJECT;
        end else if (size >= ListDepth) begin
          st = ST_FULL;
        end else begin
          list_q.insert(pos_a - 1, val);
        end
      end
      CMD_DELETE: begin
        if (pos_a < 1 || pos_a > size) begin
          st = ST_REJECT;
        end else begin
          list_q.delete(pos_a - 1);
        end
      end
      CMD_SWAP: begin
        // A self swap is fine even when the position is out of range.
        if (pos_a != pos_b) begin
          if (pos_a < 1 || pos_a > size || pos_b < 1 || pos_b > size) begin
            st = ST_REJECT;
          end else begin
            tmp = list_q[pos_a - 1];
            list_q[pos_a - 1] = list_q[pos_b - 1];
            list_q[pos_b - 1] = tmp;
          end
        end
      end
      CMD_READ_FRONT, CMD_READ_BACK: begin
        read_count++;
        if (size == 0) begin
          pending_words.push_back('{ST_EMPTY, '0, '0, 1'b1});
        end else begin
          for (int k = 0; k < size; k++) begin
            idx = (cmd == CMD_READ_BACK) ? size - 1 - k : k;
            pending_words.push_back('{ST_OK, list_q[idx], PosW'(idx + 1),
                                      k == size - 1});
          end
        end
        return;
      end
      default: st = ST_REJECT;
    endcase
    if (st == ST_FULL) full_count++;
    pending_words.push_back('{st, '0, '0, 1'b1});
  endfunction

  // Drive one command word at the falling edge and hold it until accepted.
  task automatic issue_word(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] val,
                            input logic [PosW-1:0] pos_a, input logic [PosW-1:0] pos_b);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    command_i    = cmd;
    value_i      = val;
    position_a_i = pos_a;
    position_b_i = pos_b;
    start_i      = 1'b1;
    // Taken at the first rising edge that sees busy low.
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_list_op(cmd, val, pos_a, pos_b);
    command_count++;
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic check_field(input string field_name, input logic [DataW-1:0] want,
                             input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, field_name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobed word must match the oldest pending one.
  always @(posedge clk_i) begin
    list_word_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      word_count++;
      if (pending_words.size() == 0) begin
        $display("%0t ns: unexpected word, status %0d element 0x%0h position %0d",
                 $time, status_o, element_o, element_position_o);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("status", DataW'(want.status), DataW'(status_o));
        check_field("element", want.element, element_o);
        check_field("element_position", DataW'(want.position),
                    DataW'(element_position_o));
        check_field("last", DataW'(want.last), DataW'(last_o));
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t ns: timeout after %0d cycles, %0d words still pending",
               $time, cycle_count, pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Read-outs, deletes, swaps and inserts on an empty list, plus spare command codes.
  task automatic test_empty_list();
    issue_word(CMD_READ_FRONT, '0, '0, '0);
    issue_word(CMD_READ_BACK, '0, '0, '0);
    issue_word(CMD_DELETE, '0, 5'd1, '0);
    issue_word(CMD_DELETE, '0, 5'd0, '0);
    issue_word(CMD_SWAP, '0, 5'd1, 5'd1);
    issue_word(CMD_SWAP, '0, 5'd0, 5'd0);
    issue_word(CMD_SWAP, '0, 5'd1, 5'd2);
    issue_word(CMD_INSERT, 32'h1234_5678, 5'd0, '0);
    issue_word(CMD_INSERT, 32'h1234_5678, 5'd2, '0);
    issue_word(CmdSpareLo, 32'hffff_ffff, 5'd31, 5'd31);
    issue_word(CmdSpareHi, 32'hffff_ffff, 5'd31, 5'd31);
  endtask

  // Value extremes, position edges, out-of-range and self swaps and read-outs on a short list.
  task automatic test_edits();
    issue_word(CMD_APPEND, 32'h7fff_ffff, '0, '0);
    issue_word(CMD_INSERT, 32'h8000_0000, 5'd1, '0);
    issue_word(CMD_INSERT, 32'hffff_ffff, 5'd3, '0);
    issue_word(CMD_APPEND, 32'h0000_0000, '0, '0);
    issue_word(CMD_INSERT, 32'h5555_aaaa, 5'd31, '0);
    issue_word(CMD_SWAP, '0, 5'd1, 5'd4);
    issue_word(CMD_SWAP, '0, 5'd2, 5'd5);
    issue_word(CMD_SWAP, '0, 5'd0, 5'd1);
    issue_word(CMD_SWAP, '0, 5'd31, 5'd31);
    issue_word(CMD_READ_FRONT, '0, '0, '0);
    issue_word(CMD_DELETE, '0, 5'd5, '0);
    issue_word(CMD_DELETE, '0, 5'd4, '0);
    issue_word(CMD_DELETE, '0, 5'd1, '0);
    issue_word(CMD_READ_BACK, '0, '0, '0);
  endtask

  // Fill to capacity, then push against the full list and work its ends.
  task automatic test_full_list();
    while (list_q.size() < ListDepth) begin
      issue_word(CMD_APPEND, $urandom, '0, '0);
    end
    issue_word(CMD_APPEND, 32'h0bad_0bad, '0, '0);
    issue_word(CMD_INSERT, 32'h0bad_0bad, 5'd1, '0);
    issue_word(CMD_INSERT, 32'h0bad_0bad, PosW'(ListDepth + 1), '0);
    issue_word(CMD_INSERT, 32'h0bad_0bad, PosW'(ListDepth + 2), '0);
    issue_word(CMD_SWAP, '0, 5'd1, PosW'(ListDepth));
    issue_word(CMD_READ_FRONT, '0, '0, '0);
    issue_word(CMD_READ_BACK, '0, '0, '0);
    issue_word(CMD_DELETE, '0, PosW'(ListDepth), '0);
    issue_word(CMD_DELETE, '0, PosW'(ListDepth), '0);
  endtask

  // Mostly well-formed edits and read-outs, with some raw noise mixed in.
  task automatic test_random(input int unsigned num_words, input int unsigned gap_pct);
    int unsigned size;
    int unsigned sel;
    int unsigned top;
    logic [DataW-1:0] val;
    idle_pct = gap_pct;
    for (int i = 0; i < num_words; i++) begin
      size = list_q.size();
      sel  = $urandom_range(99);
      val  = $urandom;
      top  = (size == 0) ? 1 : size;
      if (sel < 55) begin
        // Grow while short, shrink while long; the full list is still hit.
        if ($urandom_range(ListDepth + 2) >= size) begin
          if ($urandom_range(1)) begin
            issue_word(CMD_APPEND, val, PosW'($urandom), PosW'($urandom));
          end else begin
            issue_word(CMD_INSERT, val, PosW'($urandom_range(1, size + 1)),
                       PosW'($urandom));
          end
        end else begin
          issue_word(CMD_DELETE, val, PosW'($urandom_range(1, top)), PosW'($urandom));
        end
      end else if (sel < 72) begin
        issue_word(CMD_SWAP, val, PosW'($urandom_range(1, top)),
                   PosW'($urandom_range(1, top)));
      end else if (sel < 84) begin
        issue_word($urandom_range(1) ? CMD_READ_BACK : CMD_READ_FRONT, val,
                   PosW'($urandom), PosW'($urandom));
      end else begin
        issue_word(CmdW'($urandom_range(7)), val, PosW'($urandom_range(31)),
                   PosW'($urandom_range(31)));
      end
    end
  endtask

  initial begin
    int unsigned drain;
    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_edits();
    test_full_list();
    test_random(95, 0);
    test_random(95, 50);
    test_random(95, 19);

    // Wait for every owed word, then give stray words time to show.
    drain = 0;
    while (pending_words.size() != 0 && drain < 10 * ListDepth) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (ListDepth + 4) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, pending_words.size());
      mismatch_count++;
    end

    $display("Ran %0d commands (%0d read-outs), checked %0d result words.",
             command_count, read_count, word_count);
    $display("Full list refused %0d edits; %0d mismatches seen.",
             full_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
